/* hdl/b93_pkg.sv */
`timescale 1ns / 1ps

package b93_pkg;

  localparam int unsigned RADIX       = 93;
  localparam int unsigned GROUP_BYTES = 4;
  localparam int unsigned NUM_DIGITS  = 5;
  localparam int unsigned NUM_DIVS    = NUM_DIGITS - 1;
  localparam int unsigned CONV_STAGES = 2 * NUM_DIVS;
  localparam int unsigned FIFO_DEPTH  = 2;
  localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  // floor(2^38 / 93): with a 38-bit shift the estimate is the quotient or one below
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [31:0] RECIP       = 32'd2955676418;

  typedef logic [6:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] digit_vec_t;  // index 0 is the most significant

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } out_beat_t;

  // one group or message tail, handed from the front to the back
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  ndig;
    logic        last;
  } job_t;

  typedef struct packed {
    logic [31:0] val;
    logic [31:0] quo;
    digit_vec_t  dig;
    logic [2:0]  ndig;
    logic        last;
  } conv_t;

  // digit to printable ascii, skipping the double quote and the backslash
  function automatic logic [6:0] digit_to_char(input digit_t d);
    logic [6:0] c;
    if (d < 7'd2) begin
      c = d + 7'd32;
    end else if (d < 7'd59) begin
      c = d + 7'd33;
    end else begin
      c = d + 7'd34;
    end
    return c;
  endfunction

endpackage

/* hdl/b93_front.sv */
`timescale 1ns / 1ps

module b93_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  b93_pkg::in_beat_t in_data,
  output logic             job_valid,
  input  logic             job_ready,
  output b93_pkg::job_t    job_data
);

  logic [23:0] pending_bytes_r, pending_bytes_nxt;
  logic [1:0]  pending_count_r, pending_count_nxt;
  logic [2:0]  count;
  logic        full_group;
  logic        accept;

  assign count      = {1'b0, pending_count_r} + 3'd1;
  assign full_group = (count == 3'(b93_pkg::GROUP_BYTES));
  assign in_ready   = job_ready;
  assign accept     = in_valid && in_ready;

  assign job_valid      = in_valid && (full_group || in_data.end_of_message);
  assign job_data.value = {pending_bytes_r, in_data.data_byte};
  assign job_data.ndig  = full_group ? 3'(b93_pkg::NUM_DIGITS) : count + 3'd1;
  assign job_data.last  = in_data.end_of_message;

  always_comb begin
    pending_bytes_nxt = pending_bytes_r;
    pending_count_nxt = pending_count_r;
    if (accept) begin
      if (full_group || in_data.end_of_message) begin
        pending_bytes_nxt = '0;
        pending_count_nxt = '0;
      end else begin
        pending_bytes_nxt = {pending_bytes_r[15:0], in_data.data_byte};
        pending_count_nxt = count[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_bytes_r <= '0;
      pending_count_r <= '0;
    end else begin
      pending_bytes_r <= pending_bytes_nxt;
      pending_count_r <= pending_count_nxt;
    end
  end

endmodule

/* hdl/b93_fifo.sv */
`timescale 1ns / 1ps

module b93_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  b93_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output b93_pkg::job_t pop_data
);

  localparam int unsigned CNT_W = $clog2(b93_pkg::FIFO_DEPTH + 1);

  b93_pkg::job_t                  mem_r [b93_pkg::FIFO_DEPTH];
  logic [b93_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [b93_pkg::FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(b93_pkg::FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == b93_pkg::FIFO_PTR_W'(b93_pkg::FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == b93_pkg::FIFO_PTR_W'(b93_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/b93_conv.sv */
`timescale 1ns / 1ps

module b93_conv (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  b93_pkg::job_t  job_data,
  output logic           dig_valid,
  input  logic           dig_ready,
  output b93_pkg::conv_t dig_data
);

  localparam int unsigned NS = b93_pkg::CONV_STAGES;

  b93_pkg::conv_t st_r   [NS];
  b93_pkg::conv_t st_nxt [NS];
  logic [NS-1:0]  vld_r;
  logic           adv;
  b93_pkg::conv_t head;

  // whole pipeline moves together; it only holds while the last stage waits
  assign adv       = !vld_r[NS-1] || dig_ready;
  assign job_ready = adv;
  assign dig_valid = vld_r[NS-1];
  assign dig_data  = st_r[NS-1];

  always_comb begin
    head      = '0;
    head.val  = job_data.value;
    head.ndig = job_data.ndig;
    head.last = job_data.last;
  end

  always_comb begin
    b93_pkg::conv_t src;
    logic [63:0]    prod;
    logic [31:0]    rem;
    logic [31:0]    q;
    logic [31:0]    r;
    for (int s = 0; s < NS; s++) begin
      src  = (s == 0) ? head : st_r[(s == 0) ? 0 : s - 1];
      prod = '0;
      rem  = '0;
      q    = '0;
      r    = '0;
      st_nxt[s] = src;
      if ((s % 2) == 0) begin
        // quotient estimate, equal to the quotient or one short
        prod = {32'd0, src.val} * {32'd0, b93_pkg::RECIP};
        st_nxt[s].quo = 32'(prod[63:b93_pkg::RECIP_SHIFT]);
      end else begin
        rem = src.val - src.quo * 32'(b93_pkg::RADIX);
        if (rem >= 32'(b93_pkg::RADIX)) begin
          q = src.quo + 32'd1;
          r = rem - 32'(b93_pkg::RADIX);
        end else begin
          q = src.quo;
          r = rem;
        end
        st_nxt[s].val = q;
        st_nxt[s].dig[b93_pkg::NUM_DIGITS - 1 - s / 2] = r[6:0];
        if (s == NS - 1) begin
          // remaining quotient is the top digit
          st_nxt[s].dig[0] = q[6:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], job_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NS; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

endmodule

/* hdl/b93_emit.sv */
`timescale 1ns / 1ps

module b93_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               dig_valid,
  output logic               dig_ready,
  input  b93_pkg::conv_t     dig_data,
  output logic               out_valid,
  input  logic               out_ready,
  output b93_pkg::out_beat_t out_data
);

  localparam logic [2:0] LAST_POS = 3'(b93_pkg::NUM_DIGITS - 1);

  logic                busy_r, busy_nxt;
  b93_pkg::digit_vec_t digs_r;
  logic [2:0]          pos_r, pos_nxt;
  logic                last_r;
  logic                out_valid_r, out_valid_nxt;
  b93_pkg::out_beat_t  out_data_r;
  logic                load_out;
  logic                job_done;
  logic                take_job;

  assign load_out  = busy_r && (!out_valid_r || out_ready);
  assign job_done  = load_out && (pos_r == LAST_POS);
  assign dig_ready = !busy_r || job_done;
  assign take_job  = dig_valid && dig_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    busy_nxt      = busy_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      pos_nxt       = pos_r + 3'd1;
    end
    if (job_done) begin
      busy_nxt = 1'b0;
    end
    if (take_job) begin
      busy_nxt = 1'b1;
      // leading digits of a short tail are skipped
      pos_nxt  = 3'(b93_pkg::NUM_DIGITS) - dig_data.ndig;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_job) begin
      digs_r <= dig_data.dig;
      last_r <= dig_data.last;
    end
    if (load_out) begin
      out_data_r.char_code <= b93_pkg::digit_to_char(digs_r[pos_r]);
      out_data_r.last_char <= last_r && (pos_r == LAST_POS);
    end
  end

endmodule

/* hdl/base93_block_encoder_top.sv */
`timescale 1ns / 1ps

// base-93 block encoder: bytes come in one per beat, big-endian, and every four
// bytes leave as five printable characters (ascii 32..126 without the double
// quote and the backslash), most significant digit first. a message that ends
// with one to three leftover bytes gives that count plus one characters, and
// the final character of every message carries last_char. a new byte is taken
// every cycle while the two-entry job queue has room, and results leave at one
// character per cycle from the output register while out_ready is high, so the
// output port, not the input, sets the rate for a stream of full groups. the
// job for a group is written into the queue at the edge that takes the byte
// closing it, then passes the digit pipeline (four divisions by 93, each a
// reciprocal multiply stage and a correction stage), then the serializer's
// digit register and its output register, which offers the first character.

module base93_block_encoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  b93_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output b93_pkg::out_beat_t out_data
);

  // front to queue: one job per completed group or message end
  logic           fr_valid;
  logic           fr_ready;
  b93_pkg::job_t  fr_data;

  // queue to digit pipeline
  logic           q_valid;
  logic           q_ready;
  b93_pkg::job_t  q_data;

  // digit pipeline to serializer
  logic           cv_valid;
  logic           cv_ready;
  b93_pkg::conv_t cv_data;

  // byte gathering and classification
  b93_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job_data  (fr_data)
  );

  // short queue so front and back stall independently
  b93_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // radix conversion, always five digits
  b93_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job_data  (q_data),
    .dig_valid (cv_valid),
    .dig_ready (cv_ready),
    .dig_data  (cv_data)
  );

  // one character per beat, only the digits the job asks for
  b93_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .dig_valid (cv_valid),
    .dig_ready (cv_ready),
    .dig_data  (cv_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
